>>> sv/eed_pkg.sv
// Package for the backslash escape decoder: op codes, decode modes,
// character constants and the result/queue entry types.
// No dependencies.
package eed_pkg;

    localparam logic [1:0] OP_BYTE    = 2'd0;
    localparam logic [1:0] OP_ARG_END = 2'd1;
    localparam logic [1:0] OP_LAST    = 2'd2;

    localparam logic [1:0] MODE_TEXT  = 2'd0;
    localparam logic [1:0] MODE_ESC   = 2'd1;
    localparam logic [1:0] MODE_OCT   = 2'd2;

    localparam logic [7:0] CH_BSL     = 8'h5C;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_SEVEN   = 8'h37;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_B       = 8'h62;
    localparam logic [7:0] CH_F       = 8'h66;
    localparam logic [7:0] CH_N       = 8'h6E;
    localparam logic [7:0] CH_R       = 8'h72;
    localparam logic [7:0] CH_T       = 8'h74;
    localparam logic [7:0] CH_V       = 8'h76;
    localparam logic [7:0] CH_C       = 8'h63;

    localparam logic [7:0] VAL_BS     = 8'h08;
    localparam logic [7:0] VAL_FF     = 8'h0C;
    localparam logic [7:0] VAL_CR     = 8'h0D;
    localparam logic [7:0] VAL_HT     = 8'h09;
    localparam logic [7:0] VAL_VT     = 8'h0B;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       end_of_output;
    } t_result;

    typedef struct packed {
        logic    two;
        t_result first;
        t_result second;
    } t_entry;

endpackage

>>> sv/eed_front.sv
// Front end: accepts items, tracks escape/octal state and forms a queue
// entry of one or two results for each item that yields output. Holds the no_newline register.
// Depends on eed_pkg.
module eed_front
    import eed_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_op,
    input  logic [7:0] i_ch,
    input  logic       i_cfg_valid,
    input  logic       i_no_newline,
    input  logic       i_full,
    output logic       o_push,
    output t_entry     o_entry
);

    logic [1:0] r_mode, n_mode;
    logic [7:0] r_val, n_val;
    logic [1:0] r_digits, n_digits;
    logic       r_cancel, n_cancel;
    logic       r_no_newline;

    logic [1:0] cnt;
    t_result    res0, res1;
    logic       is_oct, is_digit, txt_emit;
    logic [7:0] txt_byte, oct_next;
    logic [1:0] txt_mode;
    logic       accept;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;

    always_comb begin
        n_mode   = r_mode;
        n_val    = r_val;
        n_digits = r_digits;
        n_cancel = r_cancel;
        cnt      = 2'd0;
        res0     = '0;
        res1     = '0;
        is_oct   = (r_mode == MODE_OCT);
        is_digit = i_ch inside {[CH_ZERO:CH_SEVEN]};
        oct_next = {r_val[4:0], i_ch[2:0]};
        txt_emit = 1'b0;
        txt_byte = i_ch;
        txt_mode = r_mode;
        case (i_op)
            OP_BYTE: begin
                if (is_oct && is_digit) begin
                    if (r_digits == 2'd2) begin
                        res0     = '{out_byte: oct_next, has_byte: 1'b1, end_of_output: 1'b0};
                        cnt      = 2'd1;
                        n_mode   = MODE_TEXT;
                        n_val    = '0;
                        n_digits = '0;
                    end else begin
                        n_val    = oct_next;
                        n_digits = r_digits + 2'd1;
                    end
                end else begin
                    if (is_oct) begin
                        res0     = '{out_byte: r_val, has_byte: 1'b1, end_of_output: 1'b0};
                        cnt      = 2'd1;
                        txt_mode = MODE_TEXT;
                        n_val    = '0;
                        n_digits = '0;
                    end
                    n_mode = MODE_TEXT;
                    if (txt_mode == MODE_TEXT) begin
                        if (i_ch == CH_BSL) begin
                            n_mode = MODE_ESC;
                        end else begin
                            txt_emit = 1'b1;
                        end
                    end else begin
                        case (i_ch)
                            CH_B: begin txt_emit = 1'b1; txt_byte = VAL_BS; end
                            CH_F: begin txt_emit = 1'b1; txt_byte = VAL_FF; end
                            CH_N: begin txt_emit = 1'b1; txt_byte = CH_LF;  end
                            CH_R: begin txt_emit = 1'b1; txt_byte = VAL_CR; end
                            CH_T: begin txt_emit = 1'b1; txt_byte = VAL_HT; end
                            CH_V: begin txt_emit = 1'b1; txt_byte = VAL_VT; end
                            CH_C: begin
                                n_cancel = 1'b1;
                            end
                            CH_ZERO: begin
                                n_mode   = MODE_OCT;
                                n_val    = '0;
                                n_digits = '0;
                            end
                            default: begin
                                txt_emit = 1'b1;
                            end
                        endcase
                    end
                    if (txt_emit) begin
                        if (is_oct) begin
                            res1 = '{out_byte: txt_byte, has_byte: 1'b1, end_of_output: 1'b0};
                            cnt  = 2'd2;
                        end else begin
                            res0 = '{out_byte: txt_byte, has_byte: 1'b1, end_of_output: 1'b0};
                            cnt  = 2'd1;
                        end
                    end
                end
            end
            OP_ARG_END: begin
                if (is_oct) begin
                    res0 = '{out_byte: r_val, has_byte: 1'b1, end_of_output: 1'b0};
                    res1 = '{out_byte: CH_SPACE, has_byte: 1'b1, end_of_output: 1'b0};
                    cnt  = 2'd2;
                end else begin
                    res0 = '{out_byte: CH_SPACE, has_byte: 1'b1, end_of_output: 1'b0};
                    cnt  = 2'd1;
                end
                n_mode   = MODE_TEXT;
                n_val    = '0;
                n_digits = '0;
            end
            OP_LAST: begin
                if (!r_no_newline && !r_cancel) begin
                    if (is_oct) begin
                        res0 = '{out_byte: r_val, has_byte: 1'b1, end_of_output: 1'b0};
                        res1 = '{out_byte: CH_LF, has_byte: 1'b1, end_of_output: 1'b1};
                        cnt  = 2'd2;
                    end else begin
                        res0 = '{out_byte: CH_LF, has_byte: 1'b1, end_of_output: 1'b1};
                        cnt  = 2'd1;
                    end
                end else if (is_oct) begin
                    res0 = '{out_byte: r_val, has_byte: 1'b1, end_of_output: 1'b1};
                    cnt  = 2'd1;
                end else begin
                    res0 = '{out_byte: 8'h00, has_byte: 1'b0, end_of_output: 1'b1};
                    cnt  = 2'd1;
                end
                n_mode   = MODE_TEXT;
                n_val    = '0;
                n_digits = '0;
                n_cancel = 1'b0;
            end
            default: begin
            end
        endcase
    end

    assign o_push  = accept && (cnt != 2'd0);
    assign o_entry = '{two: (cnt == 2'd2), first: res0, second: res1};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_TEXT;
            r_val        <= '0;
            r_digits     <= '0;
            r_cancel     <= 1'b0;
            r_no_newline <= 1'b0;
        end else begin
            if (accept) begin
                r_mode   <= n_mode;
                r_val    <= n_val;
                r_digits <= n_digits;
                r_cancel <= n_cancel;
            end
            if (i_cfg_valid) begin
                r_no_newline <= i_no_newline;
            end
        end
    end

endmodule

>>> sv/eed_queue.sv
// Short queue of decoded entries between front and back end.
// Flip-flop storage, one push and one pop per cycle. Depends on eed_pkg.
module eed_queue
    import eed_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output t_entry o_head,
    output logic   o_full,
    output logic   o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_entry        r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;

    assign o_head  = r_mem[r_rd];
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count < CW'(DEPTH)))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("queue pop while empty");

endmodule

>>> sv/eed_back.sv
// Back end: pops queue entries and delivers their one or two results
// through a registered output stage. Depends on eed_pkg.
module eed_back
    import eed_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_entry     i_head,
    input  logic       i_empty,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_has_byte,
    output logic       o_end_of_output
);

    t_result r_out, r_pend;
    logic    r_valid, r_pend_valid;
    logic    load;

    assign load  = !r_valid || i_ready;
    assign o_pop = load && !r_pend_valid && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_pend_valid <= 1'b0;
        end else if (load) begin
            if (r_pend_valid) begin
                r_valid      <= 1'b1;
                r_pend_valid <= 1'b0;
            end else if (!i_empty) begin
                r_valid      <= 1'b1;
                r_pend_valid <= i_head.two;
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_pend_valid) begin
                r_out <= r_pend;
            end else if (!i_empty) begin
                r_out  <= i_head.first;
                r_pend <= i_head.second;
            end
        end
    end

    assign o_valid         = r_valid;
    assign o_out_byte      = r_out.out_byte;
    assign o_has_byte      = r_out.has_byte;
    assign o_end_of_output = r_out.end_of_output;

    a_pend_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> r_valid)
        else $error("second result held without a first one in the output");

    a_two_holds_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_head.two) |=> r_pend_valid)
        else $error("second result of a popped entry lost");

endmodule

>>> sv/echo_escape_decoder.sv
// Top level of the backslash escape decoder: front end, entry queue, back end.
// Depends on eed_pkg, eed_front, eed_queue, eed_back.
//
//   channel   signals                                        direction
//   input     i_valid / o_ready, i_op, i_ch                  in
//   result    o_valid / i_ready, o_out_byte, o_has_byte,     out
//             o_end_of_output
//   config    i_cfg_valid / o_cfg_ready, i_no_newline        in
//
// One item per cycle in; results pass a registered output stage.
// Items giving two results leave as two separate outputs; the entry queue
// (QUEUE_DEPTH entries) absorbs them, and o_ready drops only when it is full.
// Synchronous active-low reset clears decode state, queue and output stage.
// Config writes are always taken (o_cfg_ready is high).
module echo_escape_decoder
    import eed_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_op,
    input  logic [7:0] i_ch,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_has_byte,
    output logic       o_end_of_output,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_no_newline
);

    t_entry push_entry, head;
    logic   push, pop, full, empty;

    assign o_cfg_ready = 1'b1;

    eed_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_op        (i_op),
        .i_ch        (i_ch),
        .i_cfg_valid (i_cfg_valid),
        .i_no_newline(i_no_newline),
        .i_full      (full),
        .o_push      (push),
        .o_entry     (push_entry)
    );

    eed_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_entry(push_entry),
        .i_pop  (pop),
        .o_head (head),
        .o_full (full),
        .o_empty(empty)
    );

    eed_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .i_empty        (empty),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_out_byte     (o_out_byte),
        .o_has_byte     (o_has_byte),
        .o_end_of_output(o_end_of_output)
    );

endmodule

>>> sim/echo_escape_decoder_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for echo_escape_decoder: directed escape, octal and
// end-of-argument items, a back-pressure burst and random argument streams.
// Depends on eed_pkg and the echo_escape_decoder RTL.
module echo_escape_decoder_tb;
    import eed_pkg::*;

    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         SETTLE_CYCLES = 16;
    localparam int         HOLD_CYCLES   = 200;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [1:0] i_op;
    logic [7:0] i_ch;
    logic       o_valid;
    logic       i_ready;
    logic [7:0] o_out_byte;
    logic       o_has_byte;
    logic       o_end_of_output;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic       i_no_newline;

    // decoder state mirror
    logic [1:0] dec_mode;
    logic [7:0] oct_value;
    logic [1:0] oct_digits;
    logic       nl_cancelled;
    logic       cfg_no_newline;

    t_result    expected_bytes[$];
    t_result    want;
    int         err_count = 0;
    bit         fast_in = 1'b0;
    bit         fast_out = 1'b0;
    bit         hold_pending = 1'b0;

    echo_escape_decoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_op            (i_op),
        .i_ch            (i_ch),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_out_byte      (o_out_byte),
        .o_has_byte      (o_has_byte),
        .o_end_of_output (o_end_of_output),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_no_newline    (i_no_newline)
    );

    always #1 i_clk = ~i_clk;

    function automatic void push_byte(logic has, logic [7:0] b, logic last);
        t_result r;
        r.out_byte      = has ? b : 8'h00;
        r.has_byte      = has;
        r.end_of_output = last;
        expected_bytes.push_back(r);
    endfunction

    function automatic void flush_octal();
        if (dec_mode == MODE_OCT) begin
            push_byte(1'b1, oct_value, 1'b0);
        end
        dec_mode   = MODE_TEXT;
        oct_value  = 8'h00;
        oct_digits = 2'd0;
    endfunction

    function automatic void decode_item(logic [1:0] op, logic [7:0] ch);
        int      base;
        t_result last_r;
        base = expected_bytes.size();
        case (op)
            OP_BYTE: begin
                if (dec_mode == MODE_OCT) begin
                    if (ch >= CH_ZERO && ch <= CH_SEVEN) begin
                        oct_value  = 8'(oct_value * 8 + (ch - CH_ZERO));
                        oct_digits = oct_digits + 2'd1;
                        if (oct_digits == 2'd3) begin
                            flush_octal();
                        end
                        return;
                    end
                    flush_octal();
                end
                if (dec_mode == MODE_TEXT) begin
                    if (ch == CH_BSL) begin
                        dec_mode = MODE_ESC;
                    end else begin
                        push_byte(1'b1, ch, 1'b0);
                    end
                end else begin
                    dec_mode = MODE_TEXT;
                    case (ch)
                        CH_B:    push_byte(1'b1, VAL_BS, 1'b0);
                        CH_F:    push_byte(1'b1, VAL_FF, 1'b0);
                        CH_N:    push_byte(1'b1, CH_LF, 1'b0);
                        CH_R:    push_byte(1'b1, VAL_CR, 1'b0);
                        CH_T:    push_byte(1'b1, VAL_HT, 1'b0);
                        CH_V:    push_byte(1'b1, VAL_VT, 1'b0);
                        CH_C:    nl_cancelled = 1'b1;
                        CH_ZERO: begin
                            dec_mode   = MODE_OCT;
                            oct_value  = 8'h00;
                            oct_digits = 2'd0;
                        end
                        default: push_byte(1'b1, ch, 1'b0);
                    endcase
                end
            end
            OP_ARG_END: begin
                flush_octal();
                push_byte(1'b1, CH_SPACE, 1'b0);
            end
            OP_LAST: begin
                flush_octal();
                if (!cfg_no_newline && !nl_cancelled) begin
                    push_byte(1'b1, CH_LF, 1'b1);
                end else if (expected_bytes.size() > base) begin
                    last_r = expected_bytes.pop_back();
                    last_r.end_of_output = 1'b1;
                    expected_bytes.push_back(last_r);
                end else begin
                    push_byte(1'b0, 8'h00, 1'b1);
                end
                nl_cancelled = 1'b0;
            end
            default: ;
        endcase
    endfunction

    task automatic send_item(input logic [1:0] op, input logic [7:0] ch);
        int gap;
        gap = fast_in ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            @(negedge i_clk) i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_op    <= op;
        i_ch    <= ch;
        do @(posedge i_clk); while (!o_ready);
        decode_item(op, ch);
    endtask

    task automatic send_escape(input logic [7:0] ch);
        send_item(OP_BYTE, CH_BSL);
        send_item(OP_BYTE, ch);
    endtask

    task automatic drain_results();
        @(negedge i_clk) i_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_no_newline(input logic value);
        drain_results();
        @(negedge i_clk);
        i_cfg_valid  <= 1'b1;
        i_no_newline <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_no_newline = value;
        @(negedge i_clk) i_cfg_valid <= 1'b0;
    endtask

    task automatic test_escapes();
        send_escape(CH_B);
        send_escape(CH_F);
        send_escape(CH_N);
        send_escape(CH_R);
        send_escape(CH_T);
        send_escape(CH_V);
        send_escape(CH_BSL);
    endtask

    task automatic test_octal();
        send_escape(CH_C);
        // \0377: third digit emits 255 at once
        send_escape(CH_ZERO);
        send_item(OP_BYTE, CH_ZERO + 8'd3);
        send_item(OP_BYTE, CH_SEVEN);
        send_item(OP_BYTE, CH_SEVEN);
        // non-digit ends an empty octal value: 0 then 0xFF
        send_escape(CH_ZERO);
        send_item(OP_BYTE, 8'hFF);
    endtask

    task automatic test_arg_ends();
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, CH_BSL);
        send_item(OP_ARG_END, 8'hFF);
        send_item(OP_UNUSED, 8'hA5);
        // newline cancelled earlier: last item emits an empty end marker
        send_item(OP_LAST, 8'h5A);
    endtask

    task automatic test_no_newline();
        write_no_newline(1'b1);
        send_escape(CH_ZERO);
        send_item(OP_BYTE, CH_ZERO + 8'd5);
        send_item(OP_LAST, 8'h00);
        write_no_newline(1'b0);
    endtask

    task automatic test_input_stall();
        int i;
        fast_in      = 1'b1;
        hold_pending = 1'b1;
        for (i = 0; i < 20; i++) begin
            send_escape(CH_ZERO);
            send_item(OP_BYTE, 8'($urandom_range(8'h41, 8'h5A)));
        end
        send_item(OP_LAST, 8'h00);
        fast_in = 1'b0;
        drain_results();
    endtask

    task automatic send_random_args(input int target);
        int sent;
        int next_switch;
        int k;
        int d;
        int j;
        logic [7:0] e;
        sent        = 0;
        next_switch = 0;
        while (sent < target) begin
            if (sent >= next_switch) begin
                fast_in     = ($urandom_range(0, 3) == 0);
                fast_out    = ($urandom_range(0, 3) == 0);
                next_switch = sent + 40;
            end
            k = $urandom_range(0, 99);
            if (k < 30) begin
                send_item(OP_BYTE, 8'($urandom_range(32, 126)));
                sent += 1;
            end else if (k < 52) begin
                case ($urandom_range(0, 9))
                    0:       e = CH_B;
                    1:       e = CH_F;
                    2:       e = CH_N;
                    3:       e = CH_R;
                    4:       e = CH_T;
                    5:       e = CH_V;
                    6:       e = CH_C;
                    7:       e = CH_BSL;
                    8:       e = CH_ZERO;
                    default: e = 8'($urandom_range(0, 255));
                endcase
                send_escape(e);
                sent += 2;
            end else if (k < 68) begin
                d = $urandom_range(0, 3);
                send_escape(CH_ZERO);
                for (j = 0; j < d; j++) begin
                    send_item(OP_BYTE, CH_ZERO + 8'($urandom_range(0, 7)));
                end
                sent += 2 + d;
                if ($urandom_range(0, 3) == 0) begin
                    send_item(OP_BYTE, CH_ZERO + 8'($urandom_range(0, 9)));
                    sent += 1;
                end
            end else if (k < 76) begin
                send_item(OP_BYTE, 8'($urandom_range(0, 255)));
                sent += 1;
            end else if (k < 85) begin
                send_item(OP_ARG_END, 8'($urandom_range(0, 255)));
                sent += 1;
            end else if (k < 90) begin
                send_item(OP_LAST, 8'($urandom_range(0, 255)));
                sent += 1;
            end else if (k < 93) begin
                send_item(OP_UNUSED, 8'($urandom_range(0, 255)));
            end else if (k < 97) begin
                send_item(OP_BYTE, CH_BSL);
                send_item($urandom_range(0, 1) ? OP_LAST : OP_ARG_END,
                          8'($urandom_range(0, 255)));
                sent += 2;
            end else begin
                send_item(OP_BYTE, 8'h00);
                sent += 1;
            end
        end
        send_item(OP_LAST, 8'($urandom_range(0, 255)));
        fast_in  = 1'b0;
        fast_out = 1'b0;
    endtask

    task automatic test_random();
        int phase;
        for (phase = 0; phase < 5; phase++) begin
            if (phase == 4) begin
                write_no_newline(1'($urandom_range(0, 1)));
            end else begin
                write_no_newline(phase[0] == 1'b0);
            end
            send_random_args(150);
        end
    endtask

    // result sink: per-result stall, plus one long hold on request
    initial begin : result_sink
        int stall;
        int hold_count;
        i_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_pending) begin
                hold_pending = 1'b0;
                stall = HOLD_CYCLES;
            end else begin
                stall = fast_out ? 0 : $urandom_range(0, 7);
            end
            if (stall > 0) begin
                @(negedge i_clk) i_ready <= 1'b0;
                for (hold_count = 1; hold_count < stall; hold_count++) @(negedge i_clk);
            end
            @(negedge i_clk) i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_bytes.size() == 0) begin
                err_count++;
                $display("%0t: unexpected item: expected none, actual byte %02h has %b end %b",
                         $time, o_out_byte, o_has_byte, o_end_of_output);
            end else begin
                want = expected_bytes.pop_front();
                if (o_out_byte !== want.out_byte) begin
                    err_count++;
                    $display("%0t: out_byte expected %02h actual %02h",
                             $time, want.out_byte, o_out_byte);
                end
                if (o_has_byte !== want.has_byte) begin
                    err_count++;
                    $display("%0t: has_byte expected %b actual %b",
                             $time, want.has_byte, o_has_byte);
                end
                if (o_end_of_output !== want.end_of_output) begin
                    err_count++;
                    $display("%0t: end_of_output expected %b actual %b",
                             $time, want.end_of_output, o_end_of_output);
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_op           = OP_BYTE;
        i_ch           = 8'h00;
        i_cfg_valid    = 1'b0;
        i_no_newline   = 1'b0;
        dec_mode       = MODE_TEXT;
        oct_value      = 8'h00;
        oct_digits     = 2'd0;
        nl_cancelled   = 1'b0;
        cfg_no_newline = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        test_escapes();
        test_octal();
        test_arg_ends();
        test_no_newline();
        test_input_stall();
        test_random();
        drain_results();

        if (err_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
sv/eed_pkg.sv
sv/eed_front.sv
sv/eed_queue.sv
sv/eed_back.sv
sv/echo_escape_decoder.sv
sim/echo_escape_decoder_tb.sv
